FILE: rtl/mmce_pkg.sv
// mmce_pkg: shared types and constants of the min/max column envelope.
// Used by the interfaces, the front, queue and back, and the top level.
package mmce_pkg;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int CMD_COL_W       = 13;     // holds a column count up to 8191
    localparam int CODE_W          = 16;
    localparam int INDEX_W         = 32;
    localparam int RCOL_W          = 10;
    localparam int NUMCOL_W        = 11;
    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CODE_W-1:0]   CODE_FULL_SCALE = 16'hFFFF;
    localparam logic [NUMCOL_W-1:0] NUM_COLUMNS_RST = 11'd1024;

    typedef enum logic [1:0] {
        REG_NUM_COLUMNS   = 2'd0,
        REG_TOTAL_SAMPLES = 2'd1,
        REG_FILL_CODE     = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_INIT,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SWEEP,
        B_RDWAIT
    } back_state_t;

    // One classified command between front and back.
    typedef struct packed {
        kind_t                kind;
        logic [CMD_COL_W-1:0] col;   // sample column, or column count for start/finish
        logic [CODE_W-1:0]    code;  // sample code, or fill code for start
        logic [RCOL_W-1:0]    rcol;
    } cmd_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: rtl/mmce_if.sv
// mmce_if: valid/ready channel interfaces for input items and result items.
// Depends on mmce_pkg for the field widths.
interface mmce_in_if
    import mmce_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [INDEX_W-1:0]  sample_index;
    logic [CODE_W-1:0]   sample_code;
    logic [RCOL_W-1:0]   read_column;

    modport source (output valid, kind, sample_index, sample_code, read_column, input ready);
    modport sink   (input valid, kind, sample_index, sample_code, read_column, output ready);
endinterface

interface mmce_out_if
    import mmce_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  column_min;
    logic [CODE_W-1:0]  column_max;

    modport source (output valid, column_min, column_max, input ready);
    modport sink   (input valid, column_min, column_max, output ready);
endinterface

FILE: rtl/mmce_front.sv
// mmce_front: accepts items, maps samples to columns with a bit-serial divider.
// Depends on mmce_pkg and mmce_in_if; feeds mmce_queue.
module mmce_front
    import mmce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    mmce_in_if.sink                                item_in,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]       cols,
    input  logic [INDEX_W-1:0]                     total,
    input  logic [CODE_W-1:0]                      fill,
    input  q_stat_t                                q_stat,
    output logic                                   q_push,
    output cmd_t                                   q_cmd
);
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NW = $clog2(MAX_COLUMNS + 1);
    localparam int PW = INDEX_W + NW;
    localparam int KW = $clog2(CW + 1);

    front_state_t        state_reg, state_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [INDEX_W-1:0]  total_reg, total_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [NW-1:0]       cols_reg, cols_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [INDEX_W-1:0]  rem_reg, rem_next;
    logic [CW-1:0]       qr_reg, qr_next;
    logic [KW-1:0]       cnt_reg, cnt_next;

    logic [INDEX_W:0]    rem_sh;
    logic                ge;
    logic [CW:0]         qr_sh;
    logic                accept;

    assign accept = item_in.valid && item_in.ready;

    always_comb
    begin
        rem_sh = {rem_reg, qr_reg[CW-1]};
        ge     = rem_sh >= {1'b0, total_reg};
        qr_sh  = {qr_reg, ge};
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        code_next     = code_reg;
        cols_next     = cols_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        qr_next       = qr_reg;
        cnt_next      = cnt_reg;
        item_in.ready = (state_reg == F_IDLE) && !q_stat.full;
        q_push        = 1'b0;
        q_cmd.kind    = kind_t'(item_in.kind);
        q_cmd.col     = CMD_COL_W'(cols);
        q_cmd.code    = (kind_t'(item_in.kind) == KIND_START) ? fill : item_in.sample_code;
        q_cmd.rcol    = item_in.read_column;

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (kind_t'(item_in.kind) != KIND_SAMPLE)
                    begin
                        q_push = 1'b1;
                    end
                    else if (total != '0 && cols != '0)
                    begin
                        idx_next   = item_in.sample_index;
                        total_next = total;
                        code_next  = item_in.sample_code;
                        cols_next  = cols;
                        if (item_in.sample_index >= total)
                        begin
                            // past the end of the record: clamp to the last column
                            qr_next    = CW'(cols - NW'(1));
                            state_next = F_PUSH;
                        end
                        else
                        begin
                            state_next = F_MUL;
                        end
                    end
                end
            end
            F_MUL:
            begin
                prod_next  = PW'(idx_reg) * PW'(cols_reg);
                state_next = F_INIT;
            end
            F_INIT:
            begin
                // quotient is below the column count, so only CW bits remain
                rem_next   = INDEX_W'(prod_reg >> CW);
                qr_next    = prod_reg[CW-1:0];
                cnt_next   = KW'(CW);
                state_next = F_DIV;
            end
            F_DIV:
            begin
                rem_next = ge ? INDEX_W'(rem_sh - {1'b0, total_reg}) : rem_sh[INDEX_W-1:0];
                qr_next  = qr_sh[CW-1:0];
                cnt_next = cnt_reg - KW'(1);
                if (cnt_reg == KW'(1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                q_cmd.kind = KIND_SAMPLE;
                q_cmd.col  = CMD_COL_W'(qr_reg);
                q_cmd.code = code_reg;
                q_cmd.rcol = '0;
                if (!q_stat.full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        total_reg <= total_next;
        code_reg  <= code_next;
        cols_reg  <= cols_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        qr_reg    <= qr_next;
        cnt_reg   <= cnt_next;
    end

endmodule

FILE: rtl/mmce_queue.sv
// mmce_queue: short command queue between front and back.
// Depends on mmce_pkg for cmd_t and q_stat_t.
module mmce_queue
    import mmce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    pop_cmd,
    output q_stat_t stat
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/mmce_back.sv
// mmce_back: runs commands against the accumulator and the trace memory.
// Depends on mmce_pkg and mmce_out_if; drains mmce_queue.
module mmce_back
    import mmce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  q_stat_t         q_stat,
    input  cmd_t            q_cmd,
    output logic            q_pop,
    mmce_out_if.source      result
);
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NW = $clog2(MAX_COLUMNS + 1);

    // low trace in the upper half of a word, high trace in the lower half
    logic [2*CODE_W-1:0] mem [MAX_COLUMNS];
    logic [2*CODE_W-1:0] rd_data_reg;

    back_state_t         state_reg, state_next;
    logic [CW-1:0]       cur_reg, cur_next;
    logic                seen_reg, seen_next;
    logic [CODE_W-1:0]   rmin_reg, rmin_next;
    logic [CODE_W-1:0]   rmax_reg, rmax_next;
    logic [CODE_W-1:0]   fill_lo_reg, fill_lo_next;
    logic [CODE_W-1:0]   fill_hi_reg, fill_hi_next;
    logic [NW-1:0]       addr_reg, addr_next;
    logic [NW-1:0]       end_reg, end_next;
    logic                oor_reg, oor_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   out_min_reg, out_min_next;
    logic [CODE_W-1:0]   out_max_reg, out_max_next;

    logic                we;
    logic [CW-1:0]       wa;
    logic [2*CODE_W-1:0] wd;
    logic [CW-1:0]       ra;
    logic [NW-1:0]       col;
    logic [NW-1:0]       cur_p1;
    logic [NW-1:0]       addr_p1;
    logic                out_free;

    assign col      = q_cmd.col[NW-1:0];
    assign cur_p1   = NW'(cur_reg) + NW'(1);
    assign addr_p1  = addr_reg + NW'(1);
    assign ra       = CW'(q_cmd.rcol);
    assign out_free = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.column_min = out_min_reg;
    assign result.column_max = out_max_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        seen_next      = seen_reg;
        rmin_next      = rmin_reg;
        rmax_next      = rmax_reg;
        fill_lo_next   = fill_lo_reg;
        fill_hi_next   = fill_hi_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        wa             = cur_reg;
        wd             = {rmin_reg, rmax_reg};

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    unique case (q_cmd.kind)
                        KIND_START:
                        begin
                            q_pop        = 1'b1;
                            fill_lo_next = q_cmd.code;
                            fill_hi_next = q_cmd.code;
                            addr_next    = '0;
                            end_next     = col;
                            cur_next     = '0;
                            seen_next    = 1'b0;
                            rmin_next    = CODE_FULL_SCALE;
                            rmax_next    = '0;
                            if (col != '0)
                            begin
                                state_next = B_SWEEP;
                            end
                        end
                        KIND_SAMPLE:
                        begin
                            q_pop = 1'b1;
                            if (col != NW'(cur_reg))
                            begin
                                if (seen_reg)
                                begin
                                    // close the column and hold the pair over skipped ones
                                    we           = 1'b1;
                                    fill_lo_next = rmin_reg;
                                    fill_hi_next = rmax_reg;
                                    addr_next    = cur_p1;
                                    end_next     = col;
                                    if (cur_p1 < col)
                                    begin
                                        state_next = B_SWEEP;
                                    end
                                end
                                cur_next  = CW'(col);
                                rmin_next = q_cmd.code;
                                rmax_next = q_cmd.code;
                            end
                            else
                            begin
                                if (q_cmd.code < rmin_reg)
                                begin
                                    rmin_next = q_cmd.code;
                                end
                                if (q_cmd.code > rmax_reg)
                                begin
                                    rmax_next = q_cmd.code;
                                end
                            end
                            seen_next = 1'b1;
                        end
                        KIND_FINISH:
                        begin
                            q_pop = 1'b1;
                            if (seen_reg)
                            begin
                                we           = 1'b1;
                                fill_lo_next = rmin_reg;
                                fill_hi_next = rmax_reg;
                                addr_next    = cur_p1;
                                end_next     = col;
                                if (cur_p1 < col)
                                begin
                                    state_next = B_SWEEP;
                                end
                            end
                        end
                        KIND_READ:
                        begin
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                oor_next   = 32'(q_cmd.rcol) >= 32'(MAX_COLUMNS);
                                state_next = B_RDWAIT;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            B_SWEEP:
            begin
                we        = 1'b1;
                wa        = addr_reg[CW-1:0];
                wd        = {fill_lo_reg, fill_hi_reg};
                addr_next = addr_p1;
                if (addr_p1 >= end_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            B_RDWAIT:
            begin
                out_valid_next = 1'b1;
                out_min_next   = oor_reg ? '0 : rd_data_reg[2*CODE_W-1:CODE_W];
                out_max_next   = oor_reg ? '0 : rd_data_reg[CODE_W-1:0];
                state_next     = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cur_reg       <= '0;
            seen_reg      <= 1'b0;
            rmin_reg      <= CODE_FULL_SCALE;
            rmax_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            seen_reg      <= seen_next;
            rmin_reg      <= rmin_next;
            rmax_reg      <= rmax_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_lo_reg <= fill_lo_next;
        fill_hi_reg <= fill_hi_next;
        addr_reg    <= addr_next;
        end_reg     <= end_next;
        oor_reg     <= oor_next;
        out_min_reg <= out_min_next;
        out_max_reg <= out_max_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

endmodule

FILE: rtl/min_max_column_envelope.sv
// min_max_column_envelope: top level with the APB register file and the assertions.
// Depends on mmce_pkg, mmce_if, mmce_front, mmce_queue and mmce_back.
//
// Usage
//   item_in carries one item per valid/ready handshake: start record, sample,
//   finish record or read column. Only a read item gives a result, on result_out
//   (column_min, column_max), held in an output register until taken.
//   Registers num_columns, total_samples and fill_code sit on the APB port at
//   byte addresses 0, 4 and 8; pready is always high, prdata returns the value.
// Timing
//   A sample keeps the front busy after it is taken: a multiply, a load of the
//   divider, one quotient bit per divider cycle and a push, which waits while
//   the queue is full; the next item is taken once the front is idle again. A
//   sample past the end of the record skips the divider and goes to the push.
//   Start, finish and read items are pushed in the same cycle they are taken.
//   The back takes a start, sample or finish from idle, then sweeps one column
//   per cycle where needed: a start writes every column in use, a column jump
//   each skipped column, a finish each column after the last one. A read is
//   popped only while the output register is free, waits in B_RDWAIT, then loads it.
// Reset and stalls
//   Reset clears the accumulator and control state; the trace memory is not
//   cleared and needs a start item before it is read. A stalled result_out
//   holds the result; the two-entry queue then fills and item_in drops ready.
module min_max_column_envelope
    import mmce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    mmce_in_if.sink                 item_in,
    mmce_out_if.source              result_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);
    localparam int NW = $clog2(MAX_COLUMNS + 1);

    logic [NUMCOL_W-1:0] num_columns_reg;
    logic [INDEX_W-1:0]  total_samples_reg;
    logic [CODE_W-1:0]   fill_code_reg;
    logic [NW-1:0]       cols_eff;
    reg_idx_t            reg_sel;
    logic                cfg_write;

    logic                q_push;
    cmd_t                q_push_cmd;
    logic                q_pop;
    cmd_t                q_pop_cmd;
    q_stat_t             q_stat;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // effective column count: the register, capped at the store depth
    assign cols_eff = (32'(num_columns_reg) < 32'(MAX_COLUMNS)) ?
                      NW'(num_columns_reg) : NW'(MAX_COLUMNS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_columns_reg   <= NUM_COLUMNS_RST;
            total_samples_reg <= '0;
            fill_code_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_NUM_COLUMNS:   num_columns_reg   <= pwdata[NUMCOL_W-1:0];
                REG_TOTAL_SAMPLES: total_samples_reg <= pwdata[INDEX_W-1:0];
                REG_FILL_CODE:     fill_code_reg     <= pwdata[CODE_W-1:0];
                default:           fill_code_reg     <= fill_code_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NUM_COLUMNS:   prdata = APB_DATA_W'(num_columns_reg);
            REG_TOTAL_SAMPLES: prdata = APB_DATA_W'(total_samples_reg);
            REG_FILL_CODE:     prdata = APB_DATA_W'(fill_code_reg);
            default:           prdata = '0;
        endcase
    end

    // front: take items, turn sample positions into columns
    mmce_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_in),
        .cols    (cols_eff),
        .total   (total_samples_reg),
        .fill    (fill_code_reg),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_cmd   (q_push_cmd)
    );

    // queue: decouple the divider from the memory sweeps
    mmce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .stat     (q_stat)
    );

    // back: accumulate, sweep the traces, answer reads
    mmce_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_cmd  (q_pop_cmd),
        .q_pop  (q_pop),
        .result (result_out)
    );

    // never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_stat.full))
        else $error("command pushed into full queue");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_stat.empty))
        else $error("command popped from empty queue");

    // a result appears only after a read command left the queue and passed B_RDWAIT
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_out.valid) |-> ($past(q_pop, 2) && $past(q_pop_cmd.kind, 2) == KIND_READ))
        else $error("result without a read command");

    // a read item on the input never reaches the queue as anything else
    a_read_kind_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready && kind_t'(item_in.kind) == KIND_READ)
        |-> (q_push && q_push_cmd.kind == KIND_READ))
        else $error("read item not queued as read");

endmodule
